// ===== rtl/core/ymbs_pkg.sv =====
`default_nettype none
package ymbs_pkg;

  localparam int DATA_BLOCK_BYTES   = 1024;
  localparam int HEADER_BLOCK_BYTES = 128;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_PAD = 8'h1A;
  localparam logic [7:0] DATA_START = (DATA_BLOCK_BYTES > 128) ? CH_STX : CH_SOH;

  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_FILE   = 2'd1;
  localparam logic [1:0] OP_RX     = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_HEADER   = 4'd1;
  localparam logic [3:0] PH_HDR_ACK  = 4'd2;
  localparam logic [3:0] PH_HDR_C    = 4'd3;
  localparam logic [3:0] PH_DATA     = 4'd4;
  localparam logic [3:0] PH_DATA_ACK = 4'd5;
  localparam logic [3:0] PH_EOT_NAK  = 4'd6;
  localparam logic [3:0] PH_EOT_ACK  = 4'd7;
  localparam logic [3:0] PH_EOT_C    = 4'd8;
  localparam logic [3:0] PH_FIN_ACK  = 4'd9;
  localparam logic [3:0] PH_DONE     = 4'd10;
  localparam logic [3:0] PH_FAILED   = 4'd11;

  localparam logic [2:0] ST_PROGRESS = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_CANCEL   = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_REFUSED  = 3'd4;

  // datapath word select
  localparam logic [2:0] SEL_NONE   = 3'd0;
  localparam logic [2:0] SEL_CONST  = 3'd1;
  localparam logic [2:0] SEL_VALUE  = 3'd2;
  localparam logic [2:0] SEL_BLK    = 3'd3;
  localparam logic [2:0] SEL_BLKN   = 3'd4;
  localparam logic [2:0] SEL_CRC_HI = 3'd5;
  localparam logic [2:0] SEL_CRC_LO = 3'd6;
  localparam logic [2:0] SEL_PAD    = 3'd7;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [10:0] tx_repeat;
    logic [2:0]  status;
    logic [3:0]  phase;
    logic        last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic       emit;       // push one result word
    logic [2:0] sel;
    logic [7:0] const_byte;
    logic [10:0] rep;       // repeat for constant words
    logic       crc_clr;
    logic       crc_val;    // fold value into crc
    logic       crc_pad;    // fold one pad or zero byte
    logic       pad_zero;   // crc_pad byte is zero rather than 0x1A
    logic       cnt_clr;
    logic       cnt_inc;
    logic       cnt_full;   // count := DATA_BLOCK_BYTES
    logic       blk_one;
    logic       blk_inc;
    logic       tmr_clr;
    logic       tmr_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic [10:0] cnt;
    logic        timed_out;   // timer after increment reaches limit
  } dp_stat_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ymbs_if.sv =====
`default_nettype none
interface ymbs_in_if;
  import ymbs_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ymbs_out_if;
  import ymbs_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ymbs_datapath.sv =====
`default_nettype none
module ymbs_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [7:0]         value,
  input  wire ymbs_pkg::dp_cmd_t  cmd,
  input  wire logic [2:0]         status,
  input  wire logic [3:0]         phase,
  input  wire logic               last,
  output ymbs_pkg::dp_stat_t      stat,
  output ymbs_pkg::out_word_t     word,
  output logic                    word_valid,
  input  wire logic               word_ready
);
  import ymbs_pkg::*;

  logic [15:0] timeout;
  logic [15:0] crc;
  logic [10:0] cnt;
  logic [7:0]  blk;
  logic [15:0] tmr;
  logic [15:0] tmr_next;
  logic [7:0]  pick;
  logic [10:0] pick_rep;

  assign tmr_next = (tmr != 16'hFFFF) ? tmr + 16'd1 : tmr;
  assign stat.cnt = cnt;
  assign stat.timed_out = (tmr_next >= timeout);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= '0;
      cnt <= '0;
      blk <= 8'd1;
      tmr <= '0;
    end else begin
      if (cmd.crc_clr) crc <= '0;
      else if (cmd.crc_val) crc <= crc_step(crc, value);
      else if (cmd.crc_pad) crc <= crc_step(crc, cmd.pad_zero ? 8'h00 : CH_PAD);
      if (cmd.cnt_clr) cnt <= '0;
      else if (cmd.cnt_full) cnt <= 11'(DATA_BLOCK_BYTES);
      else if (cmd.cnt_inc) cnt <= cnt + 11'd1;
      if (cmd.blk_one) blk <= 8'd1;
      else if (cmd.blk_inc) blk <= blk + 8'd1;
      if (cmd.tmr_clr) tmr <= '0;
      else if (cmd.tmr_inc) tmr <= tmr_next;
    end
  end

  always_comb begin
    pick = 8'h00;
    pick_rep = 11'd1;
    unique case (cmd.sel)
      SEL_NONE:   pick = 8'h00;
      SEL_CONST:  begin pick = cmd.const_byte; pick_rep = cmd.rep; end
      SEL_VALUE:  pick = value;
      SEL_BLK:    pick = blk;
      SEL_BLKN:   pick = ~blk;
      SEL_CRC_HI: pick = crc[15:8];
      SEL_CRC_LO: pick = crc[7:0];
      SEL_PAD:    begin pick = CH_PAD; pick_rep = 11'(DATA_BLOCK_BYTES) - cnt; end
      default:    pick = 8'h00;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (cmd.emit) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      word.tx_valid  <= (cmd.sel != SEL_NONE);
      word.tx_byte   <= pick;
      word.tx_repeat <= pick_rep;
      word.status    <= status;
      word.phase     <= phase;
      word.last      <= last;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ymbs_ctrl.sv =====
`default_nettype none
module ymbs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ymbs_pkg::in_word_t  in_data,
  input  wire ymbs_pkg::dp_stat_t  stat,
  input  wire logic                word_valid,
  input  wire logic                word_ready,
  output ymbs_pkg::dp_cmd_t        cmd,
  output logic [2:0]               status,
  output logic [3:0]               phase,
  output logic                     last,
  output logic [7:0]               item_value
);
  import ymbs_pkg::*;

  // sequencer steps
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_SOH     = 4'd2;
  localparam logic [3:0] S_ZERO    = 4'd3;
  localparam logic [3:0] S_FF      = 4'd4;
  localparam logic [3:0] S_BYTE    = 4'd5;
  localparam logic [3:0] S_BLK     = 4'd6;
  localparam logic [3:0] S_BLKN    = 4'd7;
  localparam logic [3:0] S_PADWORD = 4'd8;
  localparam logic [3:0] S_PADCRC  = 4'd9;
  localparam logic [3:0] S_CRCHI   = 4'd10;
  localparam logic [3:0] S_CRCLO   = 4'd11;
  localparam logic [3:0] S_NOTHING = 4'd12;
  localparam logic [3:0] S_ZBLK    = 4'd13;

  logic [3:0]  state, state_next;
  logic [3:0]  ph, ph_next;
  logic [2:0]  st, st_next;
  in_word_t    item;
  logic        ended, ended_next;
  logic        is_data, is_data_next;   // data block vs header framing
  logic        fin_blk, fin_blk_next;   // empty closing block 0
  logic [10:0] pad_cnt, pad_cnt_next;
  logic        room;
  logic [7:0]  want;
  logic        waiting;

  assign room = !word_valid || word_ready;
  assign in_ready = (state == S_IDLE);
  assign status = st_next;
  assign phase = ph_next;
  assign item_value = item.value;

  always_comb begin
    want = 8'h00;
    waiting = 1'b1;
    unique case (ph)
      PH_HDR_ACK, PH_DATA_ACK, PH_EOT_ACK, PH_FIN_ACK: want = CH_ACK;
      PH_HDR_C, PH_EOT_C: want = CH_C;
      PH_EOT_NAK: want = CH_NAK;
      default: waiting = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph <= PH_IDLE;
      st <= ST_PROGRESS;
      ended <= 1'b0;
      is_data <= 1'b0;
      fin_blk <= 1'b0;
      pad_cnt <= '0;
    end else begin
      state <= state_next;
      ph <= ph_next;
      st <= st_next;
      ended <= ended_next;
      is_data <= is_data_next;
      fin_blk <= fin_blk_next;
      pad_cnt <= pad_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_data;
  end

  always_comb begin
    state_next = state;
    ph_next = ph;
    st_next = st;
    ended_next = ended;
    is_data_next = is_data;
    fin_blk_next = fin_blk;
    pad_cnt_next = pad_cnt;
    last = 1'b0;
    cmd = '0;
    cmd.rep = 11'd1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECIDE;
          st_next = ST_PROGRESS;
        end
      end
      S_DECIDE: begin
        // hold until the output register is free
        if (room) begin
          unique case (item.op)
            OP_HEADER: begin
              if (ph == PH_IDLE || ph == PH_DONE || ph == PH_FAILED) begin
                cmd.cnt_clr = 1'b1; cmd.crc_clr = 1'b1; cmd.blk_one = 1'b1;
                cmd.tmr_clr = 1'b1;
                ended_next = 1'b0;
                ph_next = PH_HEADER;
                is_data_next = 1'b0; fin_blk_next = 1'b0;
                state_next = S_SOH;
              end else if (ph == PH_HEADER) begin
                is_data_next = 1'b0;
                if (stat.cnt + 11'd1 >= 11'(HEADER_BLOCK_BYTES)) ph_next = PH_HDR_ACK;
                state_next = S_BYTE;
              end else begin
                st_next = ST_REFUSED;
                state_next = S_NOTHING;
              end
            end
            OP_FILE: begin
              is_data_next = 1'b1;
              if (ph != PH_DATA) begin
                st_next = ST_REFUSED;
                state_next = S_NOTHING;
              end else begin
                if (item.final_byte || stat.cnt + 11'd1 >= 11'(DATA_BLOCK_BYTES))
                  ph_next = PH_DATA_ACK;
                if (stat.cnt == '0) begin
                  cmd.crc_clr = 1'b1;
                  state_next = S_SOH;
                end else begin
                  state_next = S_BYTE;
                end
              end
            end
            OP_RX: begin
              state_next = S_NOTHING;
              if (waiting && item.value == want) begin
                unique case (ph)
                  PH_HDR_ACK: begin ph_next = PH_HDR_C; cmd.tmr_clr = 1'b1; end
                  PH_HDR_C: begin ph_next = PH_DATA; cmd.cnt_clr = 1'b1; end
                  PH_DATA_ACK: begin
                    if (ended) begin
                      ph_next = PH_EOT_NAK; cmd.tmr_clr = 1'b1;
                      state_next = S_IDLE;
                      cmd.emit = 1'b1; cmd.sel = SEL_CONST; cmd.const_byte = CH_EOT;
                    end else begin
                      ph_next = PH_DATA; cmd.blk_inc = 1'b1;
                    end
                  end
                  PH_EOT_NAK: begin
                    ph_next = PH_EOT_ACK; cmd.tmr_clr = 1'b1;
                    state_next = S_IDLE;
                    cmd.emit = 1'b1; cmd.sel = SEL_CONST; cmd.const_byte = CH_EOT;
                  end
                  PH_EOT_ACK: begin ph_next = PH_EOT_C; cmd.tmr_clr = 1'b1; end
                  PH_EOT_C: begin
                    ph_next = PH_FIN_ACK; cmd.tmr_clr = 1'b1;
                    cmd.crc_clr = 1'b1;
                    is_data_next = 1'b0; fin_blk_next = 1'b1;
                    pad_cnt_next = '0;
                    state_next = S_SOH;
                  end
                  default: begin ph_next = PH_DONE; st_next = ST_COMPLETE; end
                endcase
                last = 1'b1;
              end else if (waiting && item.value == CH_CAN) begin
                ph_next = PH_FAILED; st_next = ST_CANCEL;
              end
            end
            default: begin
              state_next = S_NOTHING;
              if (waiting) begin
                cmd.tmr_inc = 1'b1;
                if (stat.timed_out) begin
                  ph_next = PH_FAILED; st_next = ST_TIMEOUT;
                end
              end
            end
          endcase
          // words emitted here belong to the EOT replies, always final
          if (!cmd.emit) last = 1'b0;
        end
      end
      S_NOTHING: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_NONE; last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SOH: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_CONST;
          cmd.const_byte = is_data ? DATA_START : CH_SOH;
          state_next = is_data ? S_BLK : S_ZERO;
        end
      end
      S_ZERO: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_CONST; cmd.const_byte = 8'h00;
          state_next = S_FF;
        end
      end
      S_FF: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_CONST; cmd.const_byte = 8'hFF;
          state_next = fin_blk ? S_ZBLK : S_BYTE;
        end
      end
      S_BLK: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_BLK;
          state_next = S_BLKN;
        end
      end
      S_BLKN: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_BLKN;
          state_next = S_BYTE;
        end
      end
      S_BYTE: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_VALUE;
          cmd.crc_val = 1'b1; cmd.cnt_inc = 1'b1;
          if (!is_data) begin
            if (stat.cnt + 11'd1 >= 11'(HEADER_BLOCK_BYTES)) begin
              state_next = S_CRCHI;
            end else begin
              last = 1'b1; state_next = S_IDLE;
            end
          end else if (item.final_byte) begin
            ended_next = 1'b1;
            state_next = (stat.cnt + 11'd1 < 11'(DATA_BLOCK_BYTES)) ? S_PADWORD : S_CRCHI;
          end else if (stat.cnt + 11'd1 >= 11'(DATA_BLOCK_BYTES)) begin
            state_next = S_CRCHI;
          end else begin
            last = 1'b1; state_next = S_IDLE;
          end
        end
      end
      S_PADWORD: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_PAD;
          cmd.cnt_full = 1'b1;
          pad_cnt_next = 11'(DATA_BLOCK_BYTES) - stat.cnt;
          state_next = S_PADCRC;
        end
      end
      S_PADCRC: begin
        // one crc step per cycle over the padding or the empty block
        cmd.crc_pad = 1'b1; cmd.pad_zero = fin_blk;
        pad_cnt_next = pad_cnt - 11'd1;
        if (pad_cnt == 11'd1) state_next = S_CRCHI;
      end
      S_ZBLK: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_CONST; cmd.const_byte = 8'h00;
          cmd.rep = 11'(HEADER_BLOCK_BYTES);
          pad_cnt_next = 11'(HEADER_BLOCK_BYTES);
          state_next = S_PADCRC;
        end
      end
      S_CRCHI: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_CRC_HI;
          state_next = S_CRCLO;
        end
      end
      S_CRCLO: begin
        if (room) begin
          cmd.emit = 1'b1; cmd.sel = SEL_CRC_LO; last = 1'b1;
          state_next = S_IDLE;
          if (!fin_blk) begin
            cmd.cnt_clr = 1'b1;
            cmd.tmr_clr = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/ymodem_batch_sender.sv =====
`default_nettype none
// ymodem batch sender, one file, crc-16 with 1k data blocks. feed header payload bytes,
// file bytes, receiver bytes and timer ticks on the input channel; framed words for the
// line come out on the output channel, each carrying a byte, a repeat count (padding and
// the empty closing block come out as one repeated word), status and phase, with last set
// on the final word of an item. an item is accepted while idle and then decoded, then emits
// its words one per cycle (up to seven words) when the output is taken at once; the eot
// reply word leaves straight from the decode step, and decode waits while the output
// register still holds an untaken word. the final file byte of a short block folds its
// pad bytes (up to 1023) into the crc one per cycle; the closing block 0 folds its 128
// zero bytes the same way, in the single-byte crc unit in the datapath. response_timeout
// may be written only while the block is idle.
module ymodem_batch_sender (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  ymbs_in_if.sink          in_ch,
  ymbs_out_if.source       out_ch
);
  import ymbs_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_word_t word;
  logic      word_valid;
  logic [2:0] status;
  logic [3:0] phase;
  logic       last;
  logic [7:0] item_value;

  // control sequencer
  ymbs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .stat(stat), .word_valid(word_valid), .word_ready(out_ch.ready),
    .cmd(cmd), .status(status), .phase(phase), .last(last),
    .item_value(item_value)
  );

  // counters, crc and output register
  ymbs_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .value(item_value), .cmd(cmd), .status(status), .phase(phase),
    .last(last), .stat(stat), .word(word), .word_valid(word_valid),
    .word_ready(out_ch.ready)
  );

  assign out_ch.valid = word_valid;
  assign out_ch.data = word;
endmodule
`default_nettype wire
